// File: sv/bb3_pkg.sv
package bb3_pkg;

   localparam int PIX_W = 8;
   localparam int CH_N = 3;
   // three 8-bit values per column, nine per window
   localparam int COLSUM_W = 10;
   localparam int WINSUM_W = 12;

   localparam int CFG_W = 11;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 11'd640;
   localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;

   // floor(x / 9) == (x * 3641) >> 15 for every x below 32768
   localparam int DIV9_MUL_W = 12;
   localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 12'd3641;
   localparam int DIV9_SHIFT = 15;
   localparam int PROD_W = WINSUM_W + DIV9_MUL_W;

   // channel 2 is red, 1 is green, 0 is blue
   typedef logic [CH_N-1:0][PIX_W-1:0] pix_type;
   typedef logic [CH_N-1:0][COLSUM_W-1:0] colsum_type;

   typedef struct packed {
      pix_type color;
      logic end_of_frame;
      logic last_of_step;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_item_type first;
      rsp_item_type second;
   } fifo_push_type;

   function automatic pix_type window_avg(input colsum_type left, input colsum_type mid,
                                          input colsum_type right);
      logic [WINSUM_W-1:0] sum;
      logic [PROD_W-1:0] prod;
      pix_type avg;
      for (int k = 0; k < CH_N; k++) begin
         sum = WINSUM_W'(left[k]) + WINSUM_W'(mid[k]) + WINSUM_W'(right[k]);
         prod = PROD_W'(sum) * PROD_W'(DIV9_MUL);
         avg[k] = prod[DIV9_SHIFT +: PIX_W];
      end
      return avg;
   endfunction

endpackage

// File: sv/box_blur_3x3_rgb.sv
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req_cmd, req_in_red/green/blue
// rsp      out        rsp_valid / rsp_ready  rsp_out_red/green/blue, end_of_frame, last_of_step
// csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One item is taken per cycle while req_ready is high; its results (0, 1 or 2) are
// computed from the stage-1 register and written into the result queue. Each line store
// has one read and one write port, so the last-row flush slides a three-column window
// and reads one new column per item. req_ready drops only while the result queue lacks
// room for two results of the item in stage 1 and two more. Reset is synchronous: counters
// clear, sizes return to 640 x 480; the line stores are not cleared. csr_ready is always high.
module box_blur_3x3_rgb import bb3_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic clock,
   input  logic reset,

   input  logic req_valid,
   output logic req_ready,
   input  logic req_cmd,
   input  logic [PIX_W-1:0] req_in_red,
   input  logic [PIX_W-1:0] req_in_green,
   input  logic [PIX_W-1:0] req_in_blue,

   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [PIX_W-1:0] rsp_out_red,
   output logic [PIX_W-1:0] rsp_out_green,
   output logic [PIX_W-1:0] rsp_out_blue,
   output logic rsp_end_of_frame,
   output logic rsp_last_of_step,

   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int FIFO_DEPTH = 8;
   localparam int CNT_W = $clog2(FIFO_DEPTH) + 1;
   localparam int LINE_W = CH_N * PIX_W;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef struct packed {
      logic flush;
      pix_type px;
      logic [COL_W-1:0] col;
      logic col_zero;
      logic col_ge2;
      logic col_last;
      logic row_ge1;
      logic row_ge2;
      logic last_row;
   } s1_type;

   logic req_fire, csr_fire;

   logic [CFG_W-1:0] width_ff, height_ff;
   logic [COL_W-1:0] wl;
   logic [ROW_W-1:0] hl;

   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic holding_ff, holding_in;

   logic s1_valid_ff, s1_valid_in;
   s1_type s1_ff, s1_in;

   logic [COL_W-1:0] rd_addr;
   logic [LINE_W-1:0] ram_a_q, ram_b_q;
   logic ram_wr_en;

   logic fwd_ff, fwd_in;
   pix_type fwd_a_ff, fwd_b_ff;
   pix_type ra, rb;

   colsum_type prev1_ff, prev2_ff;
   colsum_type s0_ff, fp1_ff, fp2_ff;
   colsum_type cur, last_sum, flush_right;
   colsum_type wa_l, wa_m, wa_r, wb_l;
   pix_type avg_a, avg_b;
   logic has0, has1;

   fifo_push_type push;
   rsp_item_type head;
   logic [CNT_W-1:0] fifo_level;
   logic [CNT_W:0] occupancy;

   assign req_fire = req_valid && req_ready;
   assign csr_fire = csr_valid && csr_ready;
   assign csr_ready = 1'b1;

   // effective sizes: zero acts as one, oversize clamps to the maximum
   always_comb begin
      if (width_ff == '0) begin
         wl = '0;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         wl = COL_W'(MAX_WIDTH - 1);
      end else begin
         wl = COL_W'(width_ff - 1'b1);
      end
      if (height_ff == '0) begin
         hl = '0;
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         hl = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         hl = ROW_W'(height_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_fire) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               width_ff <= csr_data;
            end
            REG_IMAGE_HEIGHT: begin
               height_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // stage 0: counters and the item register
   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      out_col_in = out_col_ff;
      holding_in = holding_ff;
      s1_valid_in = 1'b0;

      s1_in.flush = (req_cmd == CMD_FLUSH);
      s1_in.px = {req_in_red, req_in_green, req_in_blue};
      s1_in.col = in_col_ff;
      s1_in.col_zero = holding_ff ? (out_col_ff == '0) : (in_col_ff == '0);
      s1_in.col_last = holding_ff ? (out_col_ff == wl) : (in_col_ff == wl);
      s1_in.col_ge2 = (in_col_ff > COL_W'(1));
      s1_in.row_ge1 = (in_row_ff != '0);
      s1_in.row_ge2 = (in_row_ff > ROW_W'(1));
      s1_in.last_row = (in_row_ff == hl);

      if (csr_fire && (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT)) begin
         in_col_in = '0;
         in_row_in = '0;
         out_col_in = '0;
         holding_in = 1'b0;
      end else if (req_fire) begin
         if (req_cmd == CMD_FLUSH) begin
            if (holding_ff) begin
               s1_valid_in = 1'b1;
               if (out_col_ff == wl) begin
                  // frame done: restart
                  in_col_in = '0;
                  in_row_in = '0;
                  out_col_in = '0;
                  holding_in = 1'b0;
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
            end
         end else if (!holding_ff) begin
            s1_valid_in = 1'b1;
            if (in_col_ff == wl) begin
               in_col_in = '0;
               if (in_row_ff == hl) begin
                  holding_in = 1'b1;
                  out_col_in = '0;
                  in_row_in = '0;
               end else begin
                  in_row_in = in_row_ff + 1'b1;
               end
            end else begin
               in_col_in = in_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         holding_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         out_col_ff <= out_col_in;
         holding_ff <= holding_in;
         s1_valid_ff <= s1_valid_in;
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
   end

   // line stores: flush reads one column ahead of the output column (the same column at the last one)
   always_comb begin
      if (holding_ff) begin
         rd_addr = (out_col_ff == wl) ? out_col_ff : out_col_ff + 1'b1;
      end else begin
         rd_addr = in_col_ff;
      end
   end

   assign ram_wr_en = s1_valid_ff && !s1_ff.flush;

   bb3_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_ff.col),
      .wr_data (rb),
      .rd_addr (rd_addr),
      .rd_data (ram_a_q)
   );

   bb3_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_ff.col),
      .wr_data (s1_ff.px),
      .rd_addr (rd_addr),
      .rd_data (ram_b_q)
   );

   // bypass a read that lands on the column being written this cycle
   assign fwd_in = ram_wr_en && (rd_addr == s1_ff.col);

   always_ff @(posedge clock) begin
      fwd_a_ff <= rb;
      fwd_b_ff <= s1_ff.px;
   end

   assign ra = fwd_ff ? fwd_a_ff : pix_type'(ram_a_q);
   assign rb = fwd_ff ? fwd_b_ff : pix_type'(ram_b_q);

   // stage 1: column sums and windows
   always_comb begin
      logic [PIX_W-1:0] pk, bk, ak, fa;
      for (int k = 0; k < CH_N; k++) begin
         pk = s1_ff.px[k];
         bk = s1_ff.row_ge1 ? rb[k] : pk;
         ak = s1_ff.row_ge2 ? ra[k] : bk;
         cur[k] = COLSUM_W'(ak) + COLSUM_W'(bk) + COLSUM_W'(pk);
         last_sum[k] = COLSUM_W'(bk) + COLSUM_W'({pk, 1'b0});
         fa = (hl != '0) ? ra[k] : rb[k];
         flush_right[k] = COLSUM_W'(fa) + COLSUM_W'({rb[k], 1'b0});
      end
   end

   always_comb begin
      if (s1_ff.flush) begin
         wa_l = s1_ff.col_zero ? s0_ff : fp2_ff;
         wa_m = s1_ff.col_zero ? s0_ff : fp1_ff;
         wa_r = flush_right;
      end else begin
         wa_l = s1_ff.col_ge2 ? prev2_ff : prev1_ff;
         wa_m = prev1_ff;
         wa_r = cur;
      end
      wb_l = s1_ff.col_zero ? cur : prev1_ff;
   end

   assign avg_a = window_avg(wa_l, wa_m, wa_r);
   assign avg_b = window_avg(wb_l, cur, cur);

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         if (s1_ff.flush) begin
            fp2_ff <= wa_m;
            fp1_ff <= flush_right;
         end else begin
            prev2_ff <= prev1_ff;
            prev1_ff <= cur;
            if (s1_ff.last_row && s1_ff.col_zero) begin
               s0_ff <= last_sum;
            end
         end
      end
   end

   assign has0 = s1_ff.row_ge1 && !s1_ff.col_zero;
   assign has1 = s1_ff.row_ge1 && s1_ff.col_last;

   always_comb begin
      push.count = 2'd0;
      push.first.color = has0 ? avg_a : avg_b;
      push.first.end_of_frame = 1'b0;
      push.first.last_of_step = !(has0 && has1);
      push.second.color = avg_b;
      push.second.end_of_frame = 1'b0;
      push.second.last_of_step = 1'b1;
      if (s1_valid_ff) begin
         if (s1_ff.flush) begin
            push.count = 2'd1;
            push.first.color = avg_a;
            push.first.end_of_frame = s1_ff.col_last;
            push.first.last_of_step = 1'b1;
         end else begin
            push.count = {1'b0, has0} + {1'b0, has1};
         end
      end
   end

   bb3_rsp_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (head),
      .level     (fifo_level)
   );

   // leave room for two results of the item in flight and two of the next
   assign occupancy = (CNT_W+1)'(fifo_level) + (s1_valid_ff ? (CNT_W+1)'(2) : '0);
   assign req_ready = (occupancy <= (CNT_W+1)'(FIFO_DEPTH - 2));

   assign rsp_out_red = head.color[2];
   assign rsp_out_green = head.color[1];
   assign rsp_out_blue = head.color[0];
   assign rsp_end_of_frame = head.end_of_frame;
   assign rsp_last_of_step = head.last_of_step;

   a_fifo_room: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> ((CNT_W+1)'(fifo_level) + (CNT_W+1)'(push.count)
                       <= (CNT_W+1)'(FIFO_DEPTH)))
      else $error("result queue overflow");

   a_hold_counters: assert property (@(posedge clock) disable iff (reset)
      holding_ff |-> (in_col_ff == '0 && in_row_ff == '0))
      else $error("input counters not cleared while holding last row");

   a_flush_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == CMD_FLUSH && holding_ff && !csr_fire) |=> (push.count == 2'd1))
      else $error("flush while holding gave no result");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (in_col_ff <= wl && out_col_ff <= wl))
      else $error("column counter beyond row width");

endmodule

// File: sv/bb3_ram.sv
module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bb3_rsp_fifo.sv
module bb3_rsp_fifo import bb3_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic clock,
   input  logic reset,
   input  fifo_push_type push,
   output logic out_valid,
   input  logic out_ready,
   output rsp_item_type out_item,
   output logic [$clog2(DEPTH):0] level
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH) + 1;

   rsp_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic pop;

   assign pop = out_valid && out_ready;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_item = entry_ff[rd_ptr_ff];
   assign level = count_ff;

endmodule
